>>> rtl/reloading_down_timer_bank_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reloading down-timer bank
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RELOADING_DOWN_TIMER_BANK_DEFINES_SVH
`define RELOADING_DOWN_TIMER_BANK_DEFINES_SVH

// Same-cycle implication.
`define RDTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RDTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rdtb_pkg.sv
// ----------------------------------------------------------------------------
// rdtb_pkg
// Types and constants shared by the reloading down-timer bank modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdtb_pkg;

  localparam logic [15:0] STEP_RESET = 16'h0800;

  // Input mode codes.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [7:0] OFS_COUNT = 8'h00;
  localparam logic [7:0] OFS_CMPA  = 8'h02;
  localparam logic [7:0] OFS_CMPB  = 8'h04;
  localparam logic [7:0] OFS_CTRL  = 8'h08;
  localparam logic [7:0] OFS_MODE  = 8'h09;

  // Control and status bits.
  localparam logic [7:0] CR_START       = 8'h01;
  localparam logic [7:0] CR_RUNNING     = 8'h02;
  localparam logic [7:0] CR_UNDERFLOW   = 8'h20;
  localparam logic [7:0] CR_STATUS_BITS = 8'hE0;

  localparam int MASK_W = 10;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    REG_COUNT,
    REG_CMPA,
    REG_CMPB,
    REG_CTRL,
    REG_MODE,
    REG_NONE
  } reg_e;

  // One decoded word as it sits in the queue.
  typedef struct packed {
    op_e         op;
    logic        chan_ok;
    logic [3:0]  channel;
    reg_e        sel;
    logic [15:0] wdata;
  } item_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [16:0] divisor;
  } rem_req_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] rem;
  } rem_rsp_t;

endpackage

`default_nettype wire

>>> rtl/rdtb_front.sv
// ----------------------------------------------------------------------------
// rdtb_front
// Accepts input words, decodes mode, channel and offset, and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "reloading_down_timer_bank_defines.svh"

module rdtb_front
  import rdtb_pkg::*;
#(
  parameter int CHANNELS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  in_mode_i,
  input  wire logic [3:0]  in_channel_i,
  input  wire logic [7:0]  in_offset_i,
  input  wire logic [15:0] in_wdata_i,
  output logic             q_valid_o,
  output item_t            q_item_o,
  input  wire logic        q_pop_i
);

  item_t      dec_item;
  item_t      item_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  always_comb begin
    dec_item.channel = in_channel_i;
    dec_item.wdata   = in_wdata_i;
    dec_item.chan_ok = ({1'b0, in_channel_i} < 5'(CHANNELS));
    case (in_mode_i)
      MODE_READ:  dec_item.op = OP_READ;
      MODE_WRITE: dec_item.op = OP_WRITE;
      MODE_TICK:  dec_item.op = OP_TICK;
      default:    dec_item.op = OP_NOP;
    endcase
    case (in_offset_i)
      OFS_COUNT: dec_item.sel = REG_COUNT;
      OFS_CMPA:  dec_item.sel = REG_CMPA;
      OFS_CMPB:  dec_item.sel = REG_CMPB;
      OFS_CTRL:  dec_item.sel = REG_CTRL;
      OFS_MODE:  dec_item.sel = REG_MODE;
      default:   dec_item.sel = REG_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = item_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= dec_item;
    end
  end

  `RDTB_ASSERT_NOW(a_pop_nonempty, q_pop_i, cnt_q != 2'd0, "pop from empty queue")

endmodule

`default_nettype wire

>>> rtl/rdtb_rem.sv
// ----------------------------------------------------------------------------
// rdtb_rem
// Restoring remainder unit, one dividend bit per cycle while busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdtb_rem
  import rdtb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rem_req_t req_i,
  output rem_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] r_q, r_d;
  logic [15:0] n_q, n_d;
  logic [16:0] d_q, d_d;
  logic [16:0] trial;
  logic [15:0] r_next;

  // Shift in the next dividend bit; the partial remainder stays below the
  // divisor, so it always fits 16 bits after the conditional subtract.
  always_comb begin
    trial  = {r_q, n_q[15]};
    r_next = (trial >= d_q) ? 16'(trial - d_q) : trial[15:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    n_d    = n_q;
    d_d    = d_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
      r_d    = 16'd0;
      n_d    = req_i.dividend;
      d_d    = req_i.divisor;
    end else if (busy_q) begin
      r_d   = r_next;
      n_d   = {n_q[14:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    n_q <= n_d;
    d_q <= d_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = busy_q && (cnt_q == 4'd15);
  assign rsp_o.rem  = r_next;

endmodule

`default_nettype wire

>>> rtl/rdtb_back.sv
// ----------------------------------------------------------------------------
// rdtb_back
// Channel register file, register access, tick walk and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "reloading_down_timer_bank_defines.svh"

module rdtb_back
  import rdtb_pkg::*;
#(
  parameter int CHANNELS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        q_valid_i,
  input  wire item_t       q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      out_read_data_o,
  output logic [MASK_W-1:0] out_mask_o,
  output logic             out_event_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]        state_q;
  logic [CH_W-1:0]   walk_q;
  logic [MASK_W-1:0] mask_q;
  logic [15:0]       step_q;
  logic [15:0]       live_q   [CHANNELS];
  logic [15:0]       reload_q [CHANNELS];
  logic [15:0]       cmpa_q   [CHANNELS];
  logic [15:0]       cmpb_q   [CHANNELS];
  logic [7:0]        ctrl_q   [CHANNELS];
  logic [7:0]        mode1_q  [CHANNELS];

  logic              out_valid_q;
  logic [15:0]       out_rd_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_ev_q;

  logic [CH_W-1:0]   acc_idx;
  logic [15:0]       rd_val;
  logic [15:0]       cnt;
  logic [15:0]       rel;
  logic              running;
  logic              no_wrap;
  logic [15:0]       def_m1;
  logic              short_wrap;
  logic              uf_now;
  logic              adv_now;
  logic              wr_cnt;
  logic [15:0]       new_cnt;
  logic [MASK_W-1:0] mask_upd;
  logic              tick_pop;
  logic              out_load;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  assign q_pop_o = q_valid_i && (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc_idx = q_item_i.channel[CH_W-1:0];

  // A result word is loaded for any non-tick word at pop, or at the end of a walk.
  assign tick_pop = q_pop_o && (q_item_i.op == OP_TICK);
  assign out_load = (q_pop_o && !tick_pop)
                    || ((state_q != S_IDLE) && adv_now && (walk_q == LAST_CH));

  // Register read for the word at the head of the queue.
  always_comb begin
    rd_val = 16'd0;
    if (q_item_i.chan_ok) begin
      case (q_item_i.sel)
        REG_COUNT: rd_val = live_q[acc_idx];
        REG_CMPA:  rd_val = cmpa_q[acc_idx];
        REG_CMPB:  rd_val = cmpb_q[acc_idx];
        REG_CTRL:  rd_val = {8'd0, ctrl_q[acc_idx]};
        REG_MODE:  rd_val = {8'd0, mode1_q[acc_idx]};
        default:   rd_val = 16'd0;
      endcase
    end
  end

  // Per-channel tick arithmetic for the channel under the walk pointer.
  always_comb begin
    cnt        = live_q[walk_q];
    rel        = reload_q[walk_q];
    running    = |(ctrl_q[walk_q] & CR_START);
    no_wrap    = (cnt >= step_q);
    def_m1     = step_q - cnt - 16'd1;
    short_wrap = ({1'b0, def_m1} < ({1'b0, rel} + 17'd1));

    rem_req.start    = (state_q == S_EVAL) && running && !no_wrap && !short_wrap;
    rem_req.dividend = def_m1;
    rem_req.divisor  = {1'b0, rel} + 17'd1;

    uf_now  = 1'b0;
    adv_now = 1'b0;
    wr_cnt  = 1'b0;
    new_cnt = cnt;
    case (state_q)
      S_EVAL: begin
        if (!running) begin
          adv_now = 1'b1;
        end else if (no_wrap) begin
          adv_now = 1'b1;
          wr_cnt  = 1'b1;
          new_cnt = cnt - step_q;
        end else if (short_wrap) begin
          adv_now = 1'b1;
          wr_cnt  = 1'b1;
          uf_now  = 1'b1;
          new_cnt = rel - def_m1;
        end
      end
      S_MOD: begin
        if (rem_rsp.done) begin
          adv_now = 1'b1;
          wr_cnt  = 1'b1;
          uf_now  = 1'b1;
          new_cnt = rel - rem_rsp.rem;
        end
      end
      default: begin
        adv_now = 1'b0;
      end
    endcase

    mask_upd = mask_q;
    for (int i = 0; i < MASK_W; i++) begin
      if (uf_now && (int'(walk_q) == i)) begin
        mask_upd[i] = 1'b1;
      end
    end
  end

  rdtb_rem u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rem_req),
    .rsp_o (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= '0;
      mask_q      <= '0;
      step_q      <= STEP_RESET;
      out_valid_q <= 1'b0;
      out_rd_q    <= 16'd0;
      out_mask_q  <= '0;
      out_ev_q    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        live_q[c]   <= 16'd0;
        reload_q[c] <= 16'd0;
        cmpa_q[c]   <= 16'd0;
        cmpb_q[c]   <= 16'd0;
        ctrl_q[c]   <= 8'd0;
        mode1_q[c]  <= 8'd0;
      end
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            case (q_item_i.op)
              OP_TICK: begin
                walk_q  <= '0;
                mask_q  <= '0;
                state_q <= S_EVAL;
              end
              OP_WRITE: begin
                out_rd_q    <= 16'd0;
                out_mask_q  <= '0;
                out_ev_q    <= 1'b0;
                if (q_item_i.chan_ok) begin
                  case (q_item_i.sel)
                    REG_COUNT: begin
                      live_q[acc_idx]   <= q_item_i.wdata;
                      reload_q[acc_idx] <= q_item_i.wdata;
                    end
                    REG_CMPA: cmpa_q[acc_idx] <= q_item_i.wdata;
                    REG_CMPB: cmpb_q[acc_idx] <= q_item_i.wdata;
                    REG_CTRL: begin
                      // Status flags survive only where the written byte has a one.
                      ctrl_q[acc_idx] <= (ctrl_q[acc_idx] & q_item_i.wdata[7:0]
                                          & CR_STATUS_BITS)
                                         | (q_item_i.wdata[0] ? (CR_START | CR_RUNNING)
                                                              : 8'd0);
                    end
                    REG_MODE: mode1_q[acc_idx] <= q_item_i.wdata[7:0];
                    default: begin
                    end
                  endcase
                end
              end
              OP_READ: begin
                out_rd_q    <= rd_val;
                out_mask_q  <= '0;
                out_ev_q    <= 1'b0;
              end
              default: begin
                out_rd_q    <= 16'd0;
                out_mask_q  <= '0;
                out_ev_q    <= 1'b0;
              end
            endcase
          end
        end
        S_EVAL, S_MOD: begin
          if (wr_cnt) begin
            live_q[walk_q] <= new_cnt;
          end
          if (uf_now) begin
            ctrl_q[walk_q] <= ctrl_q[walk_q] | CR_UNDERFLOW;
          end
          if (rem_req.start) begin
            state_q <= S_MOD;
          end
          if (adv_now) begin
            mask_q <= mask_upd;
            if (walk_q == LAST_CH) begin
              out_rd_q    <= 16'd0;
              out_mask_q  <= mask_upd;
              out_ev_q    <= mask_upd[0];
              state_q     <= S_IDLE;
            end else begin
              walk_q  <= walk_q + CH_W'(1);
              state_q <= S_EVAL;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_read_data_o = out_rd_q;
  assign out_mask_o      = out_mask_q;
  assign out_event_o     = out_ev_q;

  `RDTB_ASSERT_NOW(a_walk_out_empty, state_q != S_IDLE, !out_valid_q, "result busy in walk")
  `RDTB_ASSERT_NOW(a_rem_in_mod, rem_rsp.busy, state_q == S_MOD, "remainder busy outside mod")
  `RDTB_ASSERT_NXT(a_tick_starts, tick_pop, state_q == S_EVAL, "tick did not start walk")

endmodule

`default_nettype wire

>>> rtl/reloading_down_timer_bank.sv
// A read, write or no-op word is queued, then popped when no tick walk runs and the
// result register is free, and its result is registered; such words sustain one per
// cycle while the output is ready. A tick walks the channels one per cycle, but a
// channel that wraps past more than one reload period stalls the walk in the bit-serial
// remainder unit. Two words queue ahead of the walk. Reset: all channel registers clear
// to zero, the step returns to 2048 and the queue and result register empty.
// ----------------------------------------------------------------------------
// reloading_down_timer_bank
// Bank of reloading 16-bit down-counter timers with a register access stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reloading_down_timer_bank
  import rdtb_pkg::*;
#(
  parameter int CHANNELS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // step per tick
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // channel[3:0], offset[11:4], write_data[27:12]
  input  wire logic [1:0]  s_axis_tuser,    // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata     // read_data[15:0], underflow_mask[25:16],
                                            // event_raised[26]
);

  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  logic [15:0]       out_rd;
  logic [MASK_W-1:0] out_mask;
  logic              out_ev;

  rdtb_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_channel_i(s_axis_tdata[3:0]),
    .in_offset_i (s_axis_tdata[11:4]),
    .in_wdata_i  (s_axis_tdata[27:12]),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  rdtb_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_read_data_o(out_rd),
    .out_mask_o     (out_mask),
    .out_event_o    (out_ev)
  );

  assign m_axis_tdata = {5'd0, out_ev, out_mask, out_rd};

endmodule

`default_nettype wire
